// ----- src/pcl_pkg.sv -----
package pcl_pkg;

    localparam int PULSE_W       = 12;
    localparam int WDOG_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int OUT_THRUSTERS = 6;
    localparam int OUT_BITS      = (OUT_THRUSTERS + 1) * PULSE_W;
    localparam int TDATA_W       = ((OUT_BITS + 7) / 8) * 8;
    localparam int TUSER_OUT_W   = 2;

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef logic [WDOG_W-1:0]  wdog_t;

    localparam pulse_t RST_PULSE_MIN       = 12'd1100;
    localparam pulse_t RST_PULSE_MAX       = 12'd1900;
    localparam pulse_t RST_PULSE_NEUTRAL   = 12'd1500;
    localparam pulse_t RST_GRIPPER_DEFAULT = 12'd1100;
    localparam wdog_t  RST_WATCHDOG_LIMIT  = 16'd500;
    localparam wdog_t  ELAPSED_MAX         = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_MIN       = 3'd0,
        CFG_PULSE_MAX       = 3'd1,
        CFG_PULSE_NEUTRAL   = 3'd2,
        CFG_GRIPPER_DEFAULT = 3'd3,
        CFG_WATCHDOG_LIMIT  = 3'd4
    } cfg_index_t;

    // one item held in the input register
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } step_t;

    // outcome of a newline, from the parser to the pulse bank
    typedef struct packed {
        logic apply;
        logic gripper_given;
    } line_event_t;

    typedef struct packed {
        pulse_t                        gripper;
        pulse_t [OUT_THRUSTERS-1:0]    thruster;
        logic                          timed_out;
        logic                          applied;
    } result_t;

endpackage

// ----- src/pcl_input_stage.sv -----
module pcl_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pcl_pkg::step_t in_step,
    input  logic          advance,
    output logic          held_valid,
    output pcl_pkg::step_t held_step
);
    import pcl_pkg::*;

    logic  valid_reg;
    step_t step_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_step  = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            step_reg <= in_step;
        end
    end

endmodule

// ----- src/pcl_line_parser.sv -----
module pcl_line_parser #(
    parameter int LINE_BYTES     = 96,
    parameter int THRUSTER_COUNT = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  pcl_pkg::step_t        cur,
    output pcl_pkg::line_event_t  evt,
    output pcl_pkg::pulse_t       eff_pending [0:THRUSTER_COUNT]
);
    import pcl_pkg::*;

    localparam int CHANNELS = THRUSTER_COUNT + 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int POS_W    = $clog2(LINE_BYTES);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam pulse_t     ACC_MAX  = 12'hFFF;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_ENDED  = 4'b0100,
        PH_REJECT = 4'b1000
    } line_phase_t;

    typedef enum logic [3:0] {
        TK_IDLE = 4'b0001,
        TK_LEAD = 4'b0010,
        TK_NUM  = 4'b0100,
        TK_TAIL = 4'b1000
    } token_phase_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] k);
        logic [7:0] ch;
        case (k)
            2'd0:    ch = 8'h50;
            2'd1:    ch = 8'h57;
            2'd2:    ch = 8'h4D;
            default: ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next;
    line_phase_t      phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    token_phase_t     tok_reg, tok_next;
    logic             neg_reg, neg_next;
    pulse_t           acc_reg, acc_next;
    pulse_t           pend_reg [0:THRUSTER_COUNT];

    logic        fin_ok;
    logic        fin_write;
    logic        fin_at_end;
    pulse_t      tok_value;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_space;
    logic [15:0] acc_prod;
    pulse_t      acc_digit;
    token_phase_t tok_eff;
    logic [CNT_W-1:0] end_count;

    assign c         = cur.data;
    assign fin_ok    = (tok_reg != TK_IDLE) && (cnt_reg < CNT_W'(CHANNELS));
    assign tok_value = neg_reg ? '0 : acc_reg;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign acc_prod  = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                     + {8'h00, c - CH_ZERO};
    assign acc_digit = (acc_prod > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_prod[PULSE_W-1:0];
    assign tok_eff   = (tok_reg == TK_IDLE) ? TK_LEAD : tok_reg;

    // a newline closes an open token only while still in the body
    assign fin_at_end = (phase_reg == PH_BODY) && fin_ok;
    assign end_count  = cnt_reg + CNT_W'(fin_at_end);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            eff_pending[i] = (fin_at_end && cnt_reg == CNT_W'(i)) ? tok_value : pend_reg[i];
        end
    end

    assign evt.apply = !cur.is_tick && (c == CH_LF)
                     && (phase_reg == PH_BODY || phase_reg == PH_ENDED)
                     && (end_count >= CNT_W'(THRUSTER_COUNT));
    assign evt.gripper_given = end_count > CNT_W'(THRUSTER_COUNT);

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tok_next   = tok_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        fin_write  = 1'b0;

        if (!cur.is_tick && c != CH_CR)
        begin
            if (c == CH_LF || pos_reg >= POS_W'(LINE_BYTES - 1))
            begin
                // line done or overlong: start over empty
                pos_next   = '0;
                phase_next = PH_PREFIX;
                cnt_next   = '0;
                tok_next   = TK_IDLE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (pos_reg < POS_W'(4) && c == prefix_char(pos_reg[1:0]))
                        begin
                            if (pos_reg == POS_W'(3))
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        else
                        begin
                            phase_next = PH_REJECT;
                        end
                    end
                    PH_BODY:
                    begin
                        if (c == CH_NUL || c == CH_COMMA)
                        begin
                            fin_write = fin_ok;
                            cnt_next  = cnt_reg + CNT_W'(fin_ok);
                            tok_next  = TK_IDLE;
                            neg_next  = 1'b0;
                            acc_next  = '0;
                            if (c == CH_NUL)
                            begin
                                phase_next = PH_ENDED;
                            end
                        end
                        else
                        begin
                            case (tok_eff)
                                TK_LEAD:
                                begin
                                    if (is_space)
                                    begin
                                        tok_next = TK_LEAD;
                                    end
                                    else if (c == CH_PLUS || c == CH_MINUS)
                                    begin
                                        neg_next = (c == CH_MINUS);
                                        tok_next = TK_NUM;
                                    end
                                    else if (is_digit)
                                    begin
                                        tok_next = TK_NUM;
                                        acc_next = acc_digit;
                                    end
                                    else
                                    begin
                                        tok_next = TK_TAIL;
                                    end
                                end
                                TK_NUM:
                                begin
                                    if (is_digit)
                                    begin
                                        acc_next = acc_digit;
                                    end
                                    else
                                    begin
                                        tok_next = TK_TAIL;
                                    end
                                end
                                default:
                                begin
                                    tok_next = tok_eff;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_PREFIX;
            cnt_reg   <= '0;
            tok_reg   <= TK_IDLE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tok_reg   <= tok_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // entries are only read below the value count, so no clearing
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (step && fin_write && cnt_reg == CNT_W'(i))
            begin
                pend_reg[i] <= tok_value;
            end
        end
    end

endmodule

// ----- src/pcl_pulse_bank.sv -----
module pcl_pulse_bank #(
    parameter int THRUSTER_COUNT = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 step,
    input  logic                                 out_ready,
    input  logic                                 is_tick,
    input  pcl_pkg::line_event_t                 evt,
    input  pcl_pkg::pulse_t                      eff_pending [0:THRUSTER_COUNT],
    output logic                                 out_valid,
    output pcl_pkg::result_t                     result
);
    import pcl_pkg::*;

    localparam int CHANNELS = THRUSTER_COUNT + 1;

    pulse_t  min_reg, max_reg, neutral_reg, grip_def_reg;
    wdog_t   limit_reg;
    wdog_t   elapsed_reg, elapsed_next, elapsed_inc;
    pulse_t  active_reg  [0:THRUSTER_COUNT];
    pulse_t  active_next [0:THRUSTER_COUNT];
    logic    timeout_hit;
    logic    out_valid_reg;
    result_t res_reg, res_next;

    function automatic pulse_t clamp(input pulse_t v, input pulse_t lo, input pulse_t hi);
        pulse_t r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + WDOG_W'(1) : elapsed_reg;
    assign timeout_hit = is_tick && (elapsed_inc > limit_reg);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            active_next[i] = active_reg[i];
        end
        if (is_tick)
        begin
            elapsed_next = elapsed_inc;
            if (timeout_hit)
            begin
                for (int i = 0; i < THRUSTER_COUNT; i++)
                begin
                    active_next[i] = neutral_reg;
                end
            end
        end
        else if (evt.apply)
        begin
            elapsed_next = '0;
            for (int i = 0; i < THRUSTER_COUNT; i++)
            begin
                active_next[i] = clamp(eff_pending[i], min_reg, max_reg);
            end
            active_next[THRUSTER_COUNT] = evt.gripper_given
                ? clamp(eff_pending[THRUSTER_COUNT], min_reg, max_reg) : grip_def_reg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < OUT_THRUSTERS; j++)
        begin : g_out
            if (j < THRUSTER_COUNT)
            begin : g_used
                assign res_next.thruster[j] = active_next[j];
            end
            else
            begin : g_unused
                assign res_next.thruster[j] = '0;
            end
        end
    endgenerate

    assign res_next.gripper   = active_next[THRUSTER_COUNT];
    assign res_next.applied   = !is_tick && evt.apply;
    assign res_next.timed_out = timeout_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= RST_PULSE_MIN;
            max_reg      <= RST_PULSE_MAX;
            neutral_reg  <= RST_PULSE_NEUTRAL;
            grip_def_reg <= RST_GRIPPER_DEFAULT;
            limit_reg    <= RST_WATCHDOG_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_MIN:       min_reg      <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:       max_reg      <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_NEUTRAL:   neutral_reg  <= cfg_data[PULSE_W-1:0];
                CFG_GRIPPER_DEFAULT: grip_def_reg <= cfg_data[PULSE_W-1:0];
                CFG_WATCHDOG_LIMIT:  limit_reg    <= cfg_data[WDOG_W-1:0];
                default:             limit_reg    <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THRUSTER_COUNT; i++)
            begin
                active_reg[i] <= RST_PULSE_NEUTRAL;
            end
            active_reg[THRUSTER_COUNT] <= RST_GRIPPER_DEFAULT;
        end
        else
        begin
            if (step)
            begin
                elapsed_reg <= elapsed_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    active_reg[i] <= active_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ----- src/pwm_command_line_parser.sv -----
// Serial PWM command parser. Each input transfer is a received byte
// (tuser 0) or a millisecond tick (tuser 1); each gives exactly one output
// transfer with the current six thruster and gripper pulses plus the applied
// and timed_out flags. One item is taken per clock cycle unless the output
// stalls: an input register feeds the per-byte parse, clamp and watchdog
// logic, which loads the result register. Output backpressure stalls both
// stages; the input side stays ready while the input register is empty or
// its item moves on in the same cycle.
module pwm_command_line_parser #(
    parameter int LINE_BYTES     = 96,
    parameter int THRUSTER_COUNT = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // data_byte
    input  logic                               s_axis_tuser,   // mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // thruster_0..thruster_5, gripper_pulse, zero fill
    output logic [pcl_pkg::TDATA_W-1:0]        m_axis_tdata,
    // applied, timed_out
    output logic [pcl_pkg::TUSER_OUT_W-1:0]    m_axis_tuser
);
    import pcl_pkg::*;

    step_t       in_step;
    step_t       held_step;
    logic        held_valid;
    logic        advance;
    line_event_t evt;
    pulse_t      eff_pending [0:THRUSTER_COUNT];
    result_t     result;

    assign in_step.is_tick = s_axis_tuser;
    assign in_step.data    = s_axis_tdata;
    assign advance         = held_valid && (!m_axis_tvalid || m_axis_tready);

    pcl_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_step    (in_step),
        .advance    (advance),
        .held_valid (held_valid),
        .held_step  (held_step)
    );

    pcl_line_parser #(
        .LINE_BYTES     (LINE_BYTES),
        .THRUSTER_COUNT (THRUSTER_COUNT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cur         (held_step),
        .evt         (evt),
        .eff_pending (eff_pending)
    );

    pcl_pulse_bank #(
        .THRUSTER_COUNT (THRUSTER_COUNT)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (advance),
        .out_ready   (m_axis_tready),
        .is_tick     (held_step.is_tick),
        .evt         (evt),
        .eff_pending (eff_pending),
        .out_valid   (m_axis_tvalid),
        .result      (result)
    );

    assign m_axis_tdata = {{(TDATA_W - OUT_BITS){1'b0}}, result.gripper, result.thruster};
    assign m_axis_tuser = {result.timed_out, result.applied};

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("applied and timed_out set together");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed item did not reach the result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid |-> s_axis_tready)
        else $error("input not ready with empty input register");

    a_tick_no_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held_step.is_tick) |=> !m_axis_tuser[0])
        else $error("tick reported an applied command");
`endif

endmodule

// ----- sim/tb_pwm_command_line_parser.sv -----
`timescale 1ns / 100ps

module tb_pwm_command_line_parser;
    import pcl_pkg::*;

    localparam int LINE_MAX = 96;
    localparam int CHANS    = OUT_THRUSTERS + 1;
    localparam int SAT_VAL  = 4095;
    localparam int ELAPSED_SAT = 65535;

    localparam byte unsigned NUL    = 8'h00;
    localparam byte unsigned HT     = 8'h09;
    localparam byte unsigned LF     = 8'h0A;
    localparam byte unsigned VT     = 8'h0B;
    localparam byte unsigned FF     = 8'h0C;
    localparam byte unsigned CR     = 8'h0D;
    localparam byte unsigned SP     = 8'h20;
    localparam byte unsigned PLUS   = 8'h2B;
    localparam byte unsigned COMMA  = 8'h2C;
    localparam byte unsigned MINUS  = 8'h2D;
    localparam byte unsigned DIGIT0 = 8'h30;
    localparam byte unsigned DIGIT9 = 8'h39;
    localparam string CMD_PREFIX = "PWM,";

    typedef enum int {LS_PREFIX, LS_BODY, LS_ENDED, LS_REJECT} line_state_e;
    typedef enum int {TK_IDLE, TK_LEAD, TK_NUM, TK_TAIL} token_state_e;

    typedef struct packed {
        logic [CHANS-1:0][PULSE_W-1:0] pw;
        logic                          timed_out;
        logic                          applied;
    } pulse_frame_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic [TUSER_OUT_W-1:0] m_axis_tuser;

    // predictor copy of registers and parser state
    pulse_t       cfg_min, cfg_max, cfg_neutral, cfg_grip;
    wdog_t        cfg_wd_limit;
    int unsigned  line_len, n_vals, acc, elapsed;
    line_state_e  line_st;
    token_state_e tok_st;
    bit           neg;
    int unsigned  pend [CHANS];
    pulse_t       act [CHANS];

    pulse_frame_t pulses_due [$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;
    int           tick_pct = 0;

    pwm_command_line_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void clear_line();
        line_len = 0;
        line_st  = LS_PREFIX;
        n_vals   = 0;
        tok_st   = TK_IDLE;
        neg      = 1'b0;
        acc      = 0;
        for (int i = 0; i < CHANS; i++)
            pend[i] = 0;
    endfunction

    function automatic void close_token();
        if (tok_st != TK_IDLE && n_vals < CHANS)
        begin
            pend[n_vals] = neg ? 0 : acc;
            n_vals++;
        end
        tok_st = TK_IDLE;
        neg    = 1'b0;
        acc    = 0;
    endfunction

    function automatic pulse_t clamp_pw(int unsigned v);
        if (v < cfg_min)
            return cfg_min;
        if (v > cfg_max)
            return cfg_max;
        return pulse_t'(v);
    endfunction

    function automatic void parse_body(byte unsigned c);
        if (c == NUL)
        begin
            close_token();
            line_st = LS_ENDED;
            return;
        end
        if (c == COMMA)
        begin
            close_token();
            return;
        end
        if (tok_st == TK_IDLE)
            tok_st = TK_LEAD;
        if (tok_st == TK_LEAD)
        begin
            if (c == SP || c == HT || c == VT || c == FF)
                return;
            if (c == PLUS || c == MINUS)
            begin
                neg    = (c == MINUS);
                tok_st = TK_NUM;
                return;
            end
            tok_st = TK_NUM;
        end
        if (tok_st == TK_NUM)
        begin
            if (c >= DIGIT0 && c <= DIGIT9)
            begin
                acc = acc * 10 + (c - DIGIT0);
                if (acc > SAT_VAL)
                    acc = SAT_VAL;
            end
            else
                tok_st = TK_TAIL;
        end
    endfunction

    function automatic bit close_line();
        bit ok;
        ok = 1'b0;
        if (line_st == LS_BODY)
            close_token();
        if ((line_st == LS_BODY || line_st == LS_ENDED) && n_vals >= OUT_THRUSTERS)
        begin
            for (int i = 0; i < OUT_THRUSTERS; i++)
                act[i] = clamp_pw(pend[i]);
            act[OUT_THRUSTERS] = (n_vals > OUT_THRUSTERS) ? clamp_pw(pend[OUT_THRUSTERS])
                                                          : cfg_grip;
            elapsed = 0;
            ok = 1'b1;
        end
        clear_line();
        return ok;
    endfunction

    function automatic pulse_frame_t parse_step(bit tick, byte unsigned c);
        pulse_frame_t r;
        r = '0;
        if (tick)
        begin
            if (elapsed < ELAPSED_SAT)
                elapsed++;
            if (elapsed > cfg_wd_limit)
            begin
                for (int i = 0; i < OUT_THRUSTERS; i++)
                    act[i] = cfg_neutral;
                r.timed_out = 1'b1;
            end
        end
        else if (c == LF)
            r.applied = close_line();
        else if (c != CR)
        begin
            if (line_len < LINE_MAX - 1)
            begin
                if (line_st == LS_PREFIX)
                begin
                    if (line_len < 4 && c == CMD_PREFIX[line_len])
                    begin
                        if (line_len == 3)
                            line_st = LS_BODY;
                    end
                    else
                        line_st = LS_REJECT;
                end
                else if (line_st == LS_BODY)
                    parse_body(c);
                line_len++;
            end
            else
                clear_line();
        end
        for (int i = 0; i < CHANS; i++)
            r.pw[i] = act[i];
        return r;
    endfunction

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(bit tick, byte unsigned c);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pulses_due.push_back(parse_step(tick, c));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(1'b1, byte'($urandom_range(0, 255)));
    endtask

    task automatic send_line(byte unsigned q [$]);
        foreach (q[i])
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            send_item(1'b0, q[i]);
        end
    endtask

    function automatic void push_text(ref byte unsigned q [$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    task automatic send_text(string s);
        byte unsigned q [$];
        push_text(q, s);
        send_line(q);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pulses_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // 12-bit registers get random junk in the unused top bits
    task automatic set_config(int unsigned pmin, int unsigned pmax, int unsigned pneu,
                              int unsigned pgrip, int unsigned wlim);
        wait_idle();
        write_reg(CFG_PULSE_MIN,       {4'($urandom), 12'(pmin)});
        write_reg(CFG_PULSE_MAX,       {4'($urandom), 12'(pmax)});
        write_reg(CFG_PULSE_NEUTRAL,   {4'($urandom), 12'(pneu)});
        write_reg(CFG_GRIPPER_DEFAULT, {4'($urandom), 12'(pgrip)});
        write_reg(CFG_WATCHDOG_LIMIT,  16'(wlim));
        cfg_min      = pulse_t'(pmin);
        cfg_max      = pulse_t'(pmax);
        cfg_neutral  = pulse_t'(pneu);
        cfg_grip     = pulse_t'(pgrip);
        cfg_wd_limit = wdog_t'(wlim);
    endtask

    // ---------------- output side ----------------

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 40)
            $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_pulse_frame();
        pulse_frame_t want;
        if (pulses_due.size() == 0)
        begin
            report_mismatch("unexpected transfer", m_axis_tuser, 0);
            return;
        end
        want = pulses_due.pop_front();
        for (int i = 0; i < CHANS; i++)
            if (m_axis_tdata[i*PULSE_W +: PULSE_W] !== want.pw[i])
                report_mismatch($sformatf("pulse channel %0d", i),
                                m_axis_tdata[i*PULSE_W +: PULSE_W], want.pw[i]);
        if (m_axis_tdata[TDATA_W-1:OUT_BITS] !== '0)
            report_mismatch("tdata fill", m_axis_tdata[TDATA_W-1:OUT_BITS], 0);
        if (m_axis_tuser[0] !== want.applied)
            report_mismatch("applied", m_axis_tuser[0], want.applied);
        if (m_axis_tuser[1] !== want.timed_out)
            report_mismatch("timed_out", m_axis_tuser[1], want.timed_out);
    endtask

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_pulse_frame();

    // ---------------- random content ----------------

    function automatic byte unsigned blank_char();
        case ($urandom_range(0, 3))
            0:       return SP;
            1:       return HT;
            2:       return VT;
            default: return FF;
        endcase
    endfunction

    function automatic void push_field(ref byte unsigned q [$]);
        int unsigned v;
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(800, 2200);
        case ($urandom_range(0, 11))
            0: ;  // empty field, skipped
            1:
            begin
                q.push_back(blank_char());
                push_text(q, $sformatf("%0d", v));
            end
            2:
            begin
                q.push_back($urandom_range(0, 1) ? PLUS : MINUS);
                push_text(q, $sformatf("%0d", v));
            end
            3: push_text(q, $sformatf("%0d", $urandom));
            4: push_text(q, "abc");
            5: push_text(q, $sformatf("%0d.5x", v));
            6: q.push_back(blank_char());
            default: push_text(q, $sformatf("%0d", v));
        endcase
    endfunction

    task automatic send_random_line();
        byte unsigned q [$];
        int fields, pad;
        fields = $urandom_range(5, 9);
        push_text(q, CMD_PREFIX);
        if ($urandom_range(0, 19) == 0)
            q[$urandom_range(0, 3)] = byte'($urandom_range(0, 255));
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                q.push_back(COMMA);
            push_field(q);
        end
        if ($urandom_range(0, 29) == 0)
            q.insert($urandom_range(0, q.size() - 1), NUL);
        if ($urandom_range(0, 24) == 0)
        begin
            pad = $urandom_range(93, 99);
            while (q.size() < pad)
                q.push_back(SP);
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back(CR);
        q.push_back(LF);
        send_line(q);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_tick();
        send_item(1'b0, CR);
        send_item(1'b0, LF);
        send_tick();
    endtask

    task automatic test_line_format();
        byte unsigned q [$];
        send_text("PWM,1500,1600,1700,1800,1200,1300,1400\n");
        send_text("PWM,1000,2000,1500,1500,1500,1500\r\n");
        send_text("PWM,1,2,3,4,5\n");
        send_text("PXM,1200,1200,1200,1200,1200,1200\n");
        send_text("pwm,1200,1200,1200,1200,1200,1200\n");
        send_text("PWM,\n");
        send_text("\n");
        send_text("PWM,1300,1400,1500,1600,1700,1800,1850,9,9,9\n");
        // NUL inside the prefix rejects
        push_text(q, "PW");
        q.push_back(NUL);
        push_text(q, "M,1200,1200,1200,1200,1200,1200\n");
        send_line(q);
        // NUL after the prefix ends the usable text
        q.delete();
        push_text(q, "PWM,1210,1220,1230,1240,1250,1260");
        q.push_back(NUL);
        push_text(q, ",1270\n");
        send_line(q);
    endtask

    task automatic test_field_parsing();
        byte unsigned q [$];
        push_text(q, "PWM,-5,+1234, 99999,");
        q.push_back(HT);
        q.push_back(VT);
        q.push_back(FF);
        push_text(q, "1600x,,1700,abc\n");
        send_line(q);
        send_text("PWM,-,+,1500,1500,1500,1500\n");
        send_text("PWM, ,1500,,,1600,1650,1700,1750\n");
        send_text("PWM,4294967295,0,1899,1900,1901,1100,1099\n");
    endtask

    task automatic test_clamp_settings();
        set_config(2000, 1000, 4095, 0, 500);
        send_text("PWM,1500,500,2500,1000,2000,1999\n");
        set_config(0, 4095, 0, 4095, 65535);
        send_text("PWM,0,4095,-1,12,4094,1\n");
        send_tick();
        set_config(1100, 1900, 1500, 1100, 500);
    endtask

    task automatic test_line_length();
        byte unsigned q [$];
        // exactly the largest line that fits, CR not counted
        push_text(q, "PWM,1150,1250,1350,1450,1550,1650");
        while (q.size() < LINE_MAX - 1)
            q.push_back(SP);
        q.push_back(CR);
        q.push_back(LF);
        send_line(q);
        // one byte more drops the line, the next text starts a new one
        q.delete();
        push_text(q, "PWM,1200,1200,1200,1200,1200,1200");
        while (q.size() < LINE_MAX - 1)
            q.push_back(SP);
        push_text(q, "ZPWM,1300,1300,1300,1300,1300,1300\n");
        send_line(q);
    endtask

    task automatic test_watchdog();
        set_config(1100, 1900, 1500, 1100, 3);
        send_text("PWM,1200,1300,1400,1600,1700,1800,1900\n");
        repeat (6) send_tick();
        set_config(1100, 1900, 1700, 1100, 0);
        send_text("PWM,1200,1300,1400,1600,1700,1800\n");
        repeat (2) send_tick();
        // the top limit never fires
        set_config(1100, 1900, 1600, 1100, 65535);
        send_text("PWM,1200,1300,1400,1600,1700,1800\n");
        repeat (3) send_tick();
    endtask

    task automatic test_random_traffic();
        int start, n, pick;
        tick_pct = 5;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(1100, 1900, 1500, 1100, 20);
                1: set_config(0, 4095, 0, 4095, 0);
                2: set_config(2000, 1000, 4095, 0, 7);
                3: set_config($urandom_range(0, 2000), $urandom_range(1000, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095), 65535);
                default: set_config($urandom_range(0, 2000), $urandom_range(1000, 4095),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 50));
            endcase
            quiet = (phase == 2);
            start = items_sent;
            while (items_sent - start < 8)
            begin
                if ($urandom_range(0, 19) == 0)
                    quiet = ~quiet;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_random_line();
                else if (pick < 85)
                begin
                    n = $urandom_range(1, 20);
                    repeat (n)
                        send_item(1'b0, ($urandom_range(0, 7) == 0) ? LF
                                        : byte'($urandom_range(0, 255)));
                end
                else
                begin
                    n = $urandom_range(1, 60);
                    repeat (n) send_tick();
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        cfg_min      = RST_PULSE_MIN;
        cfg_max      = RST_PULSE_MAX;
        cfg_neutral  = RST_PULSE_NEUTRAL;
        cfg_grip     = RST_GRIPPER_DEFAULT;
        cfg_wd_limit = RST_WATCHDOG_LIMIT;
        clear_line();
        for (int i = 0; i < OUT_THRUSTERS; i++)
            act[i] = RST_PULSE_NEUTRAL;
        act[OUT_THRUSTERS] = RST_GRIPPER_DEFAULT;
        elapsed = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_line_format();
        test_field_parsing();
        test_clamp_settings();
        test_line_length();
        test_watchdog();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge clk);
        if (pulses_due.size() != 0)
            report_mismatch("results still outstanding", 0, pulses_due.size());
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: outstanding transfers %0d", pulses_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- pwm_command_line_parser.f -----
src/pcl_pkg.sv
src/pcl_input_stage.sv
src/pcl_line_parser.sv
src/pcl_pulse_bank.sv
src/pwm_command_line_parser.sv
sim/tb_pwm_command_line_parser.sv
